// File: hdl/m68k_effective_address_unit_defines.svh
// assertion macros for the effective address unit
`ifndef M68K_EFFECTIVE_ADDRESS_UNIT_DEFINES_SVH
`define M68K_EFFECTIVE_ADDRESS_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define EA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define EA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/m68k_ea_pkg.sv
// types, codes and helper functions of the effective address unit
`timescale 1ns / 1ps
`default_nettype none

package m68k_ea_pkg;

    localparam int ADDR_WIDTH = 32;
    localparam logic [31:0] ADDR_MASK = 32'((64'(1) << ADDR_WIDTH) - 64'(1));

    // item kinds on the input side
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_WORD  = 2'd1;
    localparam logic [1:0] REQ_REG   = 2'd2;
    localparam logic [1:0] REQ_MEM   = 2'd3;

    // operand sizes
    localparam logic [2:0] SZ_BYTE   = 3'd0;
    localparam logic [2:0] SZ_WORD   = 3'd1;
    localparam logic [2:0] SZ_LONG   = 3'd2;
    localparam logic [2:0] SZ_DOUBLE = 3'd3;

    // mode field
    localparam logic [2:0] MODE_AIND    = 3'd2;
    localparam logic [2:0] MODE_POSTINC = 3'd3;
    localparam logic [2:0] MODE_PREDEC  = 3'd4;
    localparam logic [2:0] MODE_DISP    = 3'd5;
    localparam logic [2:0] MODE_INDEX   = 3'd6;
    localparam logic [2:0] MODE_SPECIAL = 3'd7;

    // register field under the special mode
    localparam logic [2:0] SPC_ABS_W    = 3'd0;
    localparam logic [2:0] SPC_ABS_L    = 3'd1;
    localparam logic [2:0] SPC_PC_DISP  = 3'd2;
    localparam logic [2:0] SPC_PC_INDEX = 3'd3;

    localparam logic [2:0] SP_REG = 3'd7;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_DISP      = 4'd1,
        PH_ABS_HI    = 4'd2,
        PH_ABS_LO    = 4'd3,
        PH_EXT       = 4'd4,
        PH_BRIEF_IDX = 4'd5,
        PH_BD_W      = 4'd6,
        PH_BD_HI     = 4'd7,
        PH_BD_LO     = 4'd8,
        PH_MEM_PRE   = 4'd9,
        PH_IDX       = 4'd10,
        PH_MEM_POST  = 4'd11,
        PH_OD_W      = 4'd12,
        PH_OD_HI     = 4'd13,
        PH_OD_LO     = 4'd14
    } t_phase;

    typedef enum logic [2:0] {
        K_WORD = 3'd0,
        K_REG  = 3'd1,
        K_MEM  = 3'd2,
        K_DONE = 3'd3,
        K_NONE = 3'd4
    } t_kind;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  saved_mode;
        logic [2:0]  saved_reg;
        logic [31:0] base_reg_value;
        logic [31:0] saved_pc;
        logic [15:0] ext_word;
        logic [31:0] accum_addr;
        logic [15:0] high_word;
    } t_ea_state;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  reg_sel;
        logic [31:0] address;
        logic        areg_write;
        logic [31:0] areg_value;
    } t_ea_resp;

    function automatic logic [31:0] sx16(input logic [15:0] w);
        return {{16{w[15]}}, w};
    endfunction

    function automatic logic [31:0] sx8(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    function automatic logic [1:0] expected_req(input t_phase ph);
        logic [1:0] r;
        r = REQ_WORD;
        if (ph == PH_BRIEF_IDX || ph == PH_IDX) begin
            r = REQ_REG;
        end else if (ph == PH_MEM_PRE || ph == PH_MEM_POST) begin
            r = REQ_MEM;
        end
        return r;
    endfunction

    // index register, word or long, then scaled by 1, 2, 4 or 8
    function automatic logic [31:0] scaled_index(input logic [15:0] ext, input logic [31:0] v);
        logic [31:0] x;
        x = ext[11] ? v : sx16(v[15:0]);
        return x << ext[10:9];
    endfunction

    // next stage of the full extension format, starting at stage 'step'
    function automatic t_phase walk(input logic [2:0] step, input logic [15:0] ext);
        logic [2:0] isel;
        logic       memind;
        logic       prendx;
        t_phase     ph;
        isel   = ext[2:0];
        memind = (isel != 3'd0);
        prendx = memind && !isel[2];
        ph     = PH_IDLE;
        priority if (step == 3'd0 && ext[5:4] == 2'd2) begin
            ph = PH_BD_W;
        end else if (step == 3'd0 && ext[5:4] == 2'd3) begin
            ph = PH_BD_HI;
        end else if (step <= 3'd1 && memind && !prendx) begin
            ph = PH_MEM_PRE;
        end else if (step <= 3'd2 && !ext[6]) begin
            ph = PH_IDX;
        end else if (step <= 3'd3 && prendx) begin
            ph = PH_MEM_POST;
        end else if (step <= 3'd4 && isel[1:0] == 2'd2) begin
            ph = PH_OD_W;
        end else if (step <= 3'd4 && isel[1:0] == 2'd3) begin
            ph = PH_OD_HI;
        end else begin
            ph = PH_IDLE;
        end
        return ph;
    endfunction

    function automatic t_ea_resp pending_resp(input t_phase ph, input logic [15:0] ext,
                                              input logic [31:0] acc);
        t_ea_resp r;
        r = '0;
        unique case (expected_req(ph))
            REQ_REG: begin
                r.kind    = K_REG;
                r.reg_sel = ext[15:12];
            end
            REQ_MEM: begin
                r.kind    = K_MEM;
                r.address = acc & ADDR_MASK;
            end
            default: begin
                r.kind = K_WORD;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/m68k_effective_address_unit.sv
// path: an accepted beat is registered in the input register, worked combinationally there,
// and its response is registered in the output register once that register is free
// throughput: one beat per cycle; the input register holds while a response
// waits, so the input stalls only when both stages are full
// reset: synchronous active low; clears both valid flags and the sequencer state
`timescale 1ns / 1ps
`default_nettype none

`include "m68k_effective_address_unit_defines.svh"

module m68k_effective_address_unit import m68k_ea_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [2:0]  i_ea_mode,
    input  logic [2:0]  i_ea_reg,
    input  logic [2:0]  i_op_size,
    input  logic [31:0] i_data_in,
    input  logic [31:0] i_pc_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_resp_kind,
    output logic [3:0]  o_reg_sel,
    output logic [31:0] o_address,
    output logic        o_areg_write,
    output logic [31:0] o_areg_value
);

    logic        r_iv;
    logic [1:0]  r_req_type;
    logic [2:0]  r_ea_mode;
    logic [2:0]  r_ea_reg;
    logic [2:0]  r_op_size;
    logic [31:0] r_data_in;
    logic [31:0] r_pc_in;
    t_ea_state   r_state;
    t_ea_state   n_state;
    logic        r_ov;
    t_ea_resp    r_out;
    t_ea_resp    n_out;
    logic        n_out_valid;
    logic        out_free;
    logic        process;

    assign out_free   = !r_ov || !i_out_stall;
    assign process    = r_iv && out_free;
    assign o_in_stall = r_iv && !out_free;

    m68k_ea_step u_step (
        .i_state      (r_state),
        .i_req_type   (r_req_type),
        .i_ea_mode    (r_ea_mode),
        .i_ea_reg     (r_ea_reg),
        .i_op_size    (r_op_size),
        .i_data_in    (r_data_in),
        .i_pc_in      (r_pc_in),
        .o_state      (n_state),
        .o_resp_valid (n_out_valid),
        .o_resp       (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv    <= 1'b0;
            r_ov    <= 1'b0;
            r_state <= '0;
        end else begin
            if (!r_iv || process) begin
                r_iv <= i_in_valid;
            end
            if (out_free) begin
                r_ov <= process && n_out_valid;
            end
            if (process) begin
                r_state <= n_state;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if ((!r_iv || process) && i_in_valid) begin
            r_req_type <= i_req_type;
            r_ea_mode  <= i_ea_mode;
            r_ea_reg   <= i_ea_reg;
            r_op_size  <= i_op_size;
            r_data_in  <= i_data_in;
            r_pc_in    <= i_pc_in;
        end
        if (out_free) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_resp_kind  = r_out.kind;
    assign o_reg_sel    = r_out.reg_sel;
    assign o_address    = r_out.address;
    assign o_areg_write = r_out.areg_write;
    assign o_areg_value = r_out.areg_value;

    `EA_ASSERT_NEXT(a_start_answers, process && r_req_type == REQ_START, r_ov, "start beat gave no response")
    `EA_ASSERT_NOW(a_sel_only_reg, r_ov && r_out.kind != K_REG, r_out.reg_sel == 4'd0, "reg_sel set outside a register request")
    `EA_ASSERT_NOW(a_areg_done, r_ov && r_out.areg_write, r_out.kind == K_DONE, "address register update without done")
    `EA_ASSERT_NOW(a_idle_after_done, r_ov && r_out.kind == K_DONE && !o_in_stall && !r_iv, r_state.phase == PH_IDLE, "sequencer busy after done")

endmodule

`default_nettype wire

// File: hdl/m68k_ea_step.sv
// one sequencer step: next state and response for one item
`timescale 1ns / 1ps
`default_nettype none

module m68k_ea_step import m68k_ea_pkg::*; (
    input  t_ea_state   i_state,
    input  logic [1:0]  i_req_type,
    input  logic [2:0]  i_ea_mode,
    input  logic [2:0]  i_ea_reg,
    input  logic [2:0]  i_op_size,
    input  logic [31:0] i_data_in,
    input  logic [31:0] i_pc_in,
    output t_ea_state   o_state,
    output logic        o_resp_valid,
    output t_ea_resp    o_resp
);

    always_comb begin
        t_ea_state   n;
        t_ea_resp    r;
        logic [3:0]  stepv;
        logic [31:0] nv;
        logic [15:0] w16;
        logic [31:0] base_sel;
        n        = i_state;
        r        = '0;
        stepv    = 4'd0;
        nv       = 32'd0;
        w16      = i_data_in[15:0];
        base_sel = (i_state.saved_mode == MODE_SPECIAL) ? i_state.saved_pc
                                                        : i_state.base_reg_value;
        o_resp_valid = 1'b1;

        if (i_req_type == REQ_START) begin
            n.saved_mode     = i_ea_mode;
            n.saved_reg      = i_ea_reg;
            n.base_reg_value = i_data_in;
            n.saved_pc       = i_pc_in;
            n.ext_word       = 16'd0;
            n.accum_addr     = 32'd0;
            n.high_word      = 16'd0;
            n.phase          = PH_IDLE;
            unique case (i_op_size)
                SZ_BYTE:   stepv = (i_ea_reg == SP_REG) ? 4'd2 : 4'd1;
                SZ_WORD:   stepv = 4'd2;
                SZ_LONG:   stepv = 4'd4;
                SZ_DOUBLE: stepv = 4'd8;
                default:   stepv = 4'd0;
            endcase
            unique case (i_ea_mode)
                MODE_AIND: begin
                    r.kind    = K_DONE;
                    r.address = i_data_in & ADDR_MASK;
                end
                MODE_POSTINC: begin
                    r.kind       = K_DONE;
                    r.address    = i_data_in & ADDR_MASK;
                    r.areg_write = (stepv != 4'd0);
                    r.areg_value = (stepv != 4'd0) ? i_data_in + 32'(stepv) : 32'd0;
                end
                MODE_PREDEC: begin
                    nv           = i_data_in - 32'(stepv);
                    r.kind       = K_DONE;
                    r.address    = nv & ADDR_MASK;
                    r.areg_write = (stepv != 4'd0);
                    r.areg_value = (stepv != 4'd0) ? nv : 32'd0;
                end
                MODE_DISP: begin
                    n.phase = PH_DISP;
                    r       = pending_resp(PH_DISP, 16'd0, 32'd0);
                end
                MODE_INDEX: begin
                    n.phase = PH_EXT;
                    r       = pending_resp(PH_EXT, 16'd0, 32'd0);
                end
                MODE_SPECIAL: begin
                    if (i_ea_reg == SPC_ABS_W || i_ea_reg == SPC_PC_DISP) begin
                        n.phase = PH_DISP;
                        r       = pending_resp(PH_DISP, 16'd0, 32'd0);
                    end else if (i_ea_reg == SPC_ABS_L) begin
                        n.phase = PH_ABS_HI;
                        r       = pending_resp(PH_ABS_HI, 16'd0, 32'd0);
                    end else if (i_ea_reg == SPC_PC_INDEX) begin
                        n.phase = PH_EXT;
                        r       = pending_resp(PH_EXT, 16'd0, 32'd0);
                    end else begin
                        r.kind = K_NONE;
                    end
                end
                default: begin
                    r.kind = K_NONE;
                end
            endcase
        end else if (i_state.phase == PH_IDLE) begin
            // stray beat with nothing running
            o_resp_valid = 1'b0;
        end else if (i_req_type != expected_req(i_state.phase)) begin
            r = pending_resp(i_state.phase, i_state.ext_word, i_state.accum_addr);
        end else begin
            unique case (i_state.phase)
                PH_DISP: begin
                    if (i_state.saved_mode == MODE_DISP) begin
                        n.accum_addr = i_state.base_reg_value + sx16(w16);
                    end else if (i_state.saved_reg == SPC_PC_DISP) begin
                        n.accum_addr = i_state.saved_pc + sx16(w16);
                    end else begin
                        n.accum_addr = sx16(w16);
                    end
                    n.phase = PH_IDLE;
                end
                PH_ABS_HI: begin
                    n.high_word = w16;
                    n.phase     = PH_ABS_LO;
                end
                PH_ABS_LO: begin
                    n.accum_addr = {i_state.high_word, w16};
                    n.phase      = PH_IDLE;
                end
                PH_EXT: begin
                    n.ext_word = w16;
                    if (!w16[8]) begin
                        n.phase = PH_BRIEF_IDX;
                    end else begin
                        // base suppress drops the register or pc
                        n.accum_addr = w16[7] ? 32'd0 : base_sel;
                        n.phase      = walk(3'd0, w16);
                    end
                end
                PH_BRIEF_IDX: begin
                    n.accum_addr = base_sel + sx8(i_state.ext_word[7:0])
                                 + scaled_index(i_state.ext_word, i_data_in);
                    n.phase      = PH_IDLE;
                end
                PH_BD_W: begin
                    n.accum_addr = i_state.accum_addr + sx16(w16);
                    n.phase      = walk(3'd1, i_state.ext_word);
                end
                PH_BD_HI: begin
                    n.high_word = w16;
                    n.phase     = PH_BD_LO;
                end
                PH_BD_LO: begin
                    n.accum_addr = i_state.accum_addr + {i_state.high_word, w16};
                    n.phase      = walk(3'd1, i_state.ext_word);
                end
                PH_MEM_PRE: begin
                    n.accum_addr = i_data_in;
                    n.phase      = walk(3'd2, i_state.ext_word);
                end
                PH_IDX: begin
                    n.accum_addr = i_state.accum_addr
                                 + scaled_index(i_state.ext_word, i_data_in);
                    n.phase      = walk(3'd3, i_state.ext_word);
                end
                PH_MEM_POST: begin
                    n.accum_addr = i_data_in;
                    n.phase      = walk(3'd4, i_state.ext_word);
                end
                PH_OD_W: begin
                    n.accum_addr = i_state.accum_addr + sx16(w16);
                    n.phase      = PH_IDLE;
                end
                PH_OD_HI: begin
                    n.high_word = w16;
                    n.phase     = PH_OD_LO;
                end
                default: begin
                    n.accum_addr = i_state.accum_addr + {i_state.high_word, w16};
                    n.phase      = PH_IDLE;
                end
            endcase
            if (n.phase != PH_IDLE) begin
                r = pending_resp(n.phase, n.ext_word, n.accum_addr);
            end else begin
                r.kind    = K_DONE;
                r.address = n.accum_addr & ADDR_MASK;
            end
        end

        o_state = n;
        o_resp  = r;
    end

endmodule

`default_nettype wire
